// File: sv/blob_centroid_tracker_top_macros.svh
// Assertion macros for the blob centroid tracker checker.
// Used by blob_centroid_tracker_checker.sv only.
`ifndef BLOB_CENTROID_TRACKER_TOP_MACROS_SVH
`define BLOB_CENTROID_TRACKER_TOP_MACROS_SVH

// clocked implication, disabled in reset
`define BCT_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled in reset
`define BCT_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: sv/bct_pkg.sv
// Shared types and constants for the blob centroid tracker.
// No dependencies.
`timescale 1ns / 1ps
package bct_pkg;
  localparam int CoordBits = 12;
  localparam int CountBits = 25;
  localparam int SumBits   = 36;
  localparam int DistBits  = 13;
  localparam int SqBits    = 2 * CoordBits + 2;
  localparam int RootBits  = CoordBits + 1;
  localparam int SizeBits  = 13;
  localparam int CfgIdxBits = 3;
  localparam int CfgDataBits = 25;

  localparam logic [CfgIdxBits-1:0] RegFrameWidth  = 3'd0;
  localparam logic [CfgIdxBits-1:0] RegFrameHeight = 3'd1;
  localparam logic [CfgIdxBits-1:0] RegMinPixels   = 3'd2;
  localparam logic [CfgIdxBits-1:0] RegMaxPixels   = 3'd3;
  localparam logic [CfgIdxBits-1:0] RegMinDistance = 3'd4;

  localparam logic [7:0] ObjectValue = 8'd255;
  localparam logic [DistBits-1:0] DistMax = 13'd8191;

  typedef struct packed {
    logic start;      // begin divide on captured frame
    logic load_quot;  // ready to latch divider results
  } cmd_t;

  typedef struct packed {
    logic div_done;
    logic root_done;
  } stat_t;

  typedef struct packed {
    logic [CoordBits-1:0] center_y;
    logic [CoordBits-1:0] center_x;
    logic                 accepted;
    logic [CountBits-1:0] white_count;
    logic [CoordBits-1:0] box_min_x;
    logic [CoordBits-1:0] box_max_x;
    logic [CoordBits-1:0] box_min_y;
    logic [CoordBits-1:0] box_max_y;
    logic [DistBits-1:0]  move_distance;
  } result_t;
endpackage

// File: sv/bct_ctrl.sv
// Controller for the end-of-frame back end: divide, root, decide, emit.
// Depends on bct_pkg.
`timescale 1ns / 1ps
module bct_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          frame_end,   // last pixel word accepted
  input  bct_pkg::stat_t stat,
  input  logic          out_taken,
  output bct_pkg::cmd_t cmd,
  output logic          busy,
  output logic          out_valid
);
  localparam logic [1:0] StIdle = 2'd0;
  localparam logic [1:0] StDiv  = 2'd1;
  localparam logic [1:0] StRoot = 2'd2;
  localparam logic [1:0] StOut  = 2'd3;

  logic [1:0] state, state_next;

  always_comb begin
    state_next = state;
    cmd = '0;
    case (state)
      StIdle: if (frame_end) begin
        state_next = StDiv;
        cmd.start = 1'b1;
      end
      StDiv: if (stat.div_done) begin
        state_next = StRoot;
        cmd.load_quot = 1'b1;
      end
      StRoot: if (stat.root_done) state_next = StOut;
      StOut: if (out_taken) state_next = StIdle;
      default: state_next = StIdle;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= StIdle;
    else state <= state_next;
  end

  assign busy = (state != StIdle);
  assign out_valid = (state == StOut);
endmodule

// File: sv/bct_datapath.sv
// Datapath: per-pixel accumulators, serial dividers, serial root, decision.
// Depends on bct_pkg.
`timescale 1ns / 1ps
module bct_datapath (
  input  logic clk,
  input  logic rst,
  input  logic pix_accept,
  input  logic [7:0] pixel,
  input  logic cfg_we,
  input  logic [bct_pkg::CfgIdxBits-1:0] cfg_idx,
  input  logic [bct_pkg::CfgDataBits-1:0] cfg_data,
  input  bct_pkg::cmd_t cmd,
  input  logic out_taken,
  output bct_pkg::stat_t stat,
  output logic frame_end,
  output bct_pkg::result_t result
);
  localparam int CB = bct_pkg::CoordBits;
  localparam int NB = bct_pkg::CountBits;
  localparam int SB = bct_pkg::SumBits;
  localparam int QB = bct_pkg::SqBits;
  localparam int RB = bct_pkg::RootBits;
  localparam int ZB = bct_pkg::SizeBits;
  localparam logic [ZB-1:0] SizeLimit = ZB'(1 << CB);
  localparam int DivCntBits = $clog2(SB + 1);
  localparam int RootCntBits = $clog2(RB + 1);

  localparam logic [1:0] PhIdle   = 2'd0;
  localparam logic [1:0] PhSquare = 2'd1;
  localparam logic [1:0] PhIter   = 2'd2;
  localparam logic [1:0] PhDone   = 2'd3;

  logic [ZB-1:0] frame_width, frame_height;
  logic [NB-1:0] min_pixels, max_pixels;
  logic [13:0] min_distance;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width <= ZB'(640);
      frame_height <= ZB'(480);
      min_pixels <= NB'(4500);
      max_pixels <= NB'(65000);
      min_distance <= 14'd10;
    end else if (cfg_we) begin
      case (cfg_idx)
        bct_pkg::RegFrameWidth:  frame_width <= cfg_data[ZB-1:0];
        bct_pkg::RegFrameHeight: frame_height <= cfg_data[ZB-1:0];
        bct_pkg::RegMinPixels:   min_pixels <= cfg_data;
        bct_pkg::RegMaxPixels:   max_pixels <= cfg_data;
        bct_pkg::RegMinDistance: min_distance <= cfg_data[13:0];
        default: ;
      endcase
    end
  end

  // ---- per-pixel front end ----
  logic [ZB-1:0] wclamp, hclamp;
  logic [CB-1:0] last_col, last_row;
  always_comb begin
    wclamp = (frame_width == '0) ? ZB'(1) :
             (frame_width > SizeLimit) ? SizeLimit : frame_width;
    hclamp = (frame_height == '0) ? ZB'(1) :
             (frame_height > SizeLimit) ? SizeLimit : frame_height;
    last_col = CB'(wclamp - ZB'(1));
    last_row = CB'(hclamp - ZB'(1));
  end

  logic [CB-1:0] col, row, least_x, most_x, least_y, most_y;
  logic [NB-1:0] white;
  logic [SB-1:0] col_sum, row_sum;
  logic hit, end_row;

  assign hit = (pixel == bct_pkg::ObjectValue);
  assign end_row = (col >= last_col);
  assign frame_end = pix_accept && end_row && (row >= last_row);

  always_ff @(posedge clk) begin
    if (rst || frame_end) begin
      col <= '0; row <= '0; white <= '0;
      least_x <= '1; most_x <= '0; least_y <= '1; most_y <= '0;
      col_sum <= '0; row_sum <= '0;
    end else if (pix_accept) begin
      if (hit) begin
        white <= white + NB'(1);
        if (col < least_x) least_x <= col;
        if (col > most_x) most_x <= col;
        if (row < least_y) least_y <= row;
        if (row > most_y) most_y <= row;
        col_sum <= col_sum + SB'(col);
        row_sum <= row_sum + SB'(row);
      end
      if (end_row) begin
        col <= '0;
        row <= row + CB'(1);
      end else begin
        col <= col + CB'(1);
      end
    end
  end

  // ---- frame capture (final pixel included) ----
  logic [NB-1:0] f_white;
  logic [CB-1:0] f_lx, f_mx, f_ly, f_my;
  logic [NB:0] biased;
  always_ff @(posedge clk) begin
    if (frame_end) begin
      f_white <= hit ? white + NB'(1) : white;
      f_lx <= (hit && col < least_x) ? col : least_x;
      f_mx <= (hit && col > most_x) ? col : most_x;
      f_ly <= (hit && row < least_y) ? row : least_y;
      f_my <= (hit && row > most_y) ? row : most_y;
    end
  end
  assign biased = {1'b0, f_white} + (NB+1)'(1);

  // ---- two restoring dividers, one quotient bit per cycle ----
  logic [SB-1:0] qx, qy;
  logic [NB:0] rx, ry;
  logic [DivCntBits-1:0] div_cnt;
  logic div_run;
  logic [NB+1:0] trx, try_;
  always_comb begin
    trx = {rx, qx[SB-1]} - {1'b0, biased};
    try_ = {ry, qy[SB-1]} - {1'b0, biased};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      div_run <= 1'b0;
    end else if (cmd.start) begin
      div_run <= 1'b1;
    end else if (div_run && div_cnt == DivCntBits'(SB - 1)) begin
      div_run <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      qx <= hit ? col_sum + SB'(col) : col_sum;
      qy <= hit ? row_sum + SB'(row) : row_sum;
      rx <= '0; ry <= '0;
      div_cnt <= '0;
    end else if (div_run) begin
      div_cnt <= div_cnt + DivCntBits'(1);
      if (!trx[NB+1]) begin
        rx <= trx[NB:0]; qx <= {qx[SB-2:0], 1'b1};
      end else begin
        rx <= {rx[NB-1:0], qx[SB-1]}; qx <= {qx[SB-2:0], 1'b0};
      end
      if (!try_[NB+1]) begin
        ry <= try_[NB:0]; qy <= {qy[SB-2:0], 1'b1};
      end else begin
        ry <= {ry[NB-1:0], qy[SB-1]}; qy <= {qy[SB-2:0], 1'b0};
      end
    end
  end
  assign stat.div_done = !div_run && !cmd.start;

  // ---- squared distance then serial integer root ----
  logic [CB-1:0] prev_x, prev_y, cx, cy;
  logic first;
  logic [CB-1:0] adx, ady;
  logic [2*CB-1:0] sqx, sqy;
  logic [QB-1:0] rem, sq_total;
  logic [RB-1:0] root;
  logic [RootCntBits-1:0] root_cnt;
  logic [1:0] root_phase;
  logic [QB+1:0] trial;

  always_comb begin
    adx = (prev_x >= qx[CB-1:0]) ? prev_x - qx[CB-1:0] : qx[CB-1:0] - prev_x;
    ady = (prev_y >= qy[CB-1:0]) ? prev_y - qy[CB-1:0] : qy[CB-1:0] - prev_y;
    trial = {2'b00, rem[QB-3:0], sq_total[QB-1:QB-2]} -
            {{(QB-RB){1'b0}}, root, 2'b01};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      root_phase <= PhIdle;
    end else if (cmd.load_quot) begin
      root_phase <= PhSquare;
    end else if (root_phase == PhSquare) begin
      root_phase <= PhIter;
    end else if (root_phase == PhIter && root_cnt == RootCntBits'(RB - 1)) begin
      root_phase <= PhDone;
    end else if (out_taken) begin
      root_phase <= PhIdle;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_quot) begin
      cx <= qx[CB-1:0]; cy <= qy[CB-1:0];
      sqx <= adx * adx; sqy <= ady * ady;
    end
    if (root_phase == PhSquare) begin
      sq_total <= QB'(sqx) + QB'(sqy);
      rem <= '0; root <= '0; root_cnt <= '0;
    end else if (root_phase == PhIter) begin
      root_cnt <= root_cnt + RootCntBits'(1);
      sq_total <= {sq_total[QB-3:0], 2'b00};
      if (!trial[QB+1]) begin
        rem <= trial[QB-1:0]; root <= {root[RB-2:0], 1'b1};
      end else begin
        rem <= {rem[QB-3:0], sq_total[QB-1:QB-2]}; root <= {root[RB-2:0], 1'b0};
      end
    end
  end
  assign stat.root_done = (root_phase == PhDone);

  // round: remainder s - r*r above r bumps the root
  logic [RB:0] mv_dist;
  logic reject;
  assign mv_dist = (QB'(rem) > QB'(root)) ? {1'b0, root} + (RB+1)'(1) : {1'b0, root};
  always_comb begin
    reject = !first && ((biased < {1'b0, min_pixels}) || (biased > {1'b0, max_pixels}) ||
             (mv_dist < min_distance));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prev_x <= '0; prev_y <= '0; first <= 1'b1;
    end else if (out_taken) begin
      prev_x <= reject ? prev_x : cx;
      prev_y <= reject ? prev_y : cy;
      first <= 1'b0;
    end
  end

  always_comb begin
    result.center_x = reject ? prev_x : cx;
    result.center_y = reject ? prev_y : cy;
    result.accepted = !reject;
    result.white_count = f_white;
    result.box_min_x = f_lx;
    result.box_max_x = f_mx;
    result.box_min_y = f_ly;
    result.box_max_y = f_my;
    result.move_distance = (mv_dist > (RB+1)'(bct_pkg::DistMax)) ? bct_pkg::DistMax
                                                               : bct_pkg::DistBits'(mv_dist);
  end
endmodule

// File: sv/blob_centroid_tracker_top.sv
// Top level of the blob centroid tracker.
// Depends on bct_pkg, bct_ctrl, bct_datapath.
`timescale 1ns / 1ps
// Usage:
//  s_axis carries one mask pixel per word (tdata[7:0]); 255 is object.
//  Pixels stream in raster order at one per clock while the back end is idle.
//  After the last pixel of a frame, m_axis gives one result word: centroid,
//  accept flag, white count, bounding box and rounded move distance.
//  End of frame: after the last pixel is accepted, m_axis_tvalid rises once the
//  back end has run its steps in order: bit-serial divide (two 36-bit sums by
//  count+1 in parallel), square, sum, bit-serial root, then present.
//  s_axis_tready is low from the last pixel until the result is taken, so a
//  stalled receiver holds the result and pauses the pixel stream.
//  Pixel rate inside a frame: one per cycle.
//  Config: cfg_we/cfg_idx/cfg_data, write only while idle.
//  rst (synchronous) restores default registers, clears counters, sets the
//  first-frame flag and the previous point to (0,0).
module blob_centroid_tracker_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] pixel
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [11:0] center_x, [23:12] center_y, [24] accepted, [49:25] white_count,
  // [61:50] box_min_x, [73:62] box_max_x, [85:74] box_min_y,
  // [97:86] box_max_y, [110:98] move_distance, [111] zero
  output logic [111:0] m_axis_tdata,
  input  logic        cfg_we,
  input  logic [bct_pkg::CfgIdxBits-1:0] cfg_idx,
  input  logic [bct_pkg::CfgDataBits-1:0] cfg_data
);
  bct_pkg::cmd_t cmd;
  bct_pkg::stat_t stat;
  bct_pkg::result_t res;
  logic busy, frame_end, pix_accept, out_taken;

  assign s_axis_tready = !busy;
  assign pix_accept = s_axis_tvalid && s_axis_tready;
  assign out_taken = m_axis_tvalid && m_axis_tready;

  bct_ctrl u_ctrl (
    .clk(clk), .rst(rst), .frame_end(frame_end), .stat(stat),
    .out_taken(out_taken), .cmd(cmd), .busy(busy), .out_valid(m_axis_tvalid)
  );

  bct_datapath u_dp (
    .clk(clk), .rst(rst), .pix_accept(pix_accept), .pixel(s_axis_tdata),
    .cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_data(cfg_data), .cmd(cmd),
    .out_taken(out_taken), .stat(stat), .frame_end(frame_end), .result(res)
  );

  assign m_axis_tdata = {1'b0, res.move_distance, res.box_max_y, res.box_min_y,
                         res.box_max_x, res.box_min_x, res.white_count,
                         res.accepted, res.center_y, res.center_x};
endmodule

// File: sv/blob_centroid_tracker_checker.sv
// Port-level checks for blob_centroid_tracker_top, attached by bind.
// Depends on blob_centroid_tracker_top_macros.svh.
`timescale 1ns / 1ps
`include "blob_centroid_tracker_top_macros.svh"
module blob_centroid_tracker_checker (
  input logic         clk,
  input logic         rst,
  input logic         s_axis_tready,
  input logic         m_axis_tvalid,
  input logic         m_axis_tready,
  input logic [111:0] m_axis_tdata
);
  // input and output never open together
  `BCT_ASSERT_IMPL(a_excl, m_axis_tvalid, !s_axis_tready, "ready while result pending")
  // stalled result holds
  `BCT_ASSERT_NEXT(a_hold, m_axis_tvalid && !m_axis_tready,
    m_axis_tvalid && $stable(m_axis_tdata), "result changed under stall")
  // empty box implies zero count
  `BCT_ASSERT_IMPL(a_box, m_axis_tvalid && m_axis_tdata[61:50] > m_axis_tdata[73:62],
    m_axis_tdata[49:25] == 25'd0, "inverted box with white pixels")
  // after a taken result input reopens
  `BCT_ASSERT_NEXT(a_reopen, m_axis_tvalid && m_axis_tready, s_axis_tready,
    "input not reopened")
endmodule

bind blob_centroid_tracker_top blob_centroid_tracker_checker u_chk (
  .clk(clk), .rst(rst), .s_axis_tready(s_axis_tready),
  .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
  .m_axis_tdata(m_axis_tdata)
);
